FILE: hdl/rhsv_pkg.sv
package rhsv_pkg;

    // Pixel and result widths
    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 16;

    // Hue divisor 6*chroma needs three more bits than a channel
    localparam int HDIV_BITS = CHANNEL_BITS + 3;
    // Signed working width of the sector numerator
    localparam int HNUM_BITS = HDIV_BITS + 1;

    // One quotient bit per cell; the longer of the two quotients sets the chain length
    localparam int STEPS = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

    // Stream word widths, padded to whole bytes
    localparam int IN_BITS      = 3 * CHANNEL_BITS;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = HUE_BITS + 2 * CHANNEL_BITS;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [HDIV_BITS-1:0]    hdiv_t;
    typedef logic [HUE_BITS-1:0]     hue_t;

    // Partial state of both dividers as it walks down the cell chain
    typedef struct packed {
        hdiv_t                 hue_rem;
        hdiv_t                 hue_div;
        hue_t                  hue_q;
        chan_t                 sat_rem;
        logic [CHANNEL_BITS:0] sat_div;
        chan_t                 sat_low;
        chan_t                 sat_q;
        chan_t                 value;
    } div_word_t;

endpackage

FILE: hdl/rhsv_prep.sv
module rhsv_prep
    import rhsv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [IN_TDATA_W-1:0] up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output div_word_t             dn_word
);

    chan_t                    red;
    chan_t                    green;
    chan_t                    blue;
    chan_t                    vmax;
    chan_t                    vmin;
    chan_t                    chroma;
    logic [HNUM_BITS-1:0]     c_ext;
    logic [HNUM_BITS-1:0]     six_c;
    logic [HNUM_BITS-1:0]     n_raw;
    logic [HNUM_BITS-1:0]     n_adj;
    logic [2*CHANNEL_BITS-1:0] sat_num;
    div_word_t                word_next;
    div_word_t                word_reg;
    logic                     valid_reg;

    assign red   = up_data[CHANNEL_BITS-1:0];
    assign green = up_data[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign blue  = up_data[3*CHANNEL_BITS-1:2*CHANNEL_BITS];

    // Max and min of the three channels
    always_comb
    begin
        vmax = (red > green) ? red : green;
        if (blue > vmax)
            vmax = blue;
        vmin = (red < green) ? red : green;
        if (blue < vmin)
            vmin = blue;
    end

    assign chroma = vmax - vmin;
    assign c_ext  = HNUM_BITS'(chroma);
    assign six_c  = (c_ext << 2) + (c_ext << 1);

    // Sector numerator, red wins ties over green, green over blue
    always_comb
    begin
        if (vmax == red)
            n_raw = HNUM_BITS'(green) - HNUM_BITS'(blue);
        else if (vmax == green)
            n_raw = (c_ext << 1) + HNUM_BITS'(blue) - HNUM_BITS'(red);
        else
            n_raw = (c_ext << 2) + HNUM_BITS'(red) - HNUM_BITS'(green);
        n_adj = n_raw[HNUM_BITS-1] ? (n_raw + six_c) : n_raw;
    end

    // CMAX * chroma as a shift and subtract
    assign sat_num = {chroma, {CHANNEL_BITS{1'b0}}} - (2*CHANNEL_BITS)'(chroma);

    // Seed both dividers; a zero divisor is replaced by all ones so the quotient stays zero
    always_comb
    begin
        word_next.hue_rem = n_adj[HDIV_BITS-1:0];
        word_next.hue_div = (chroma == '0) ? '1 : six_c[HDIV_BITS-1:0];
        word_next.hue_q   = '0;
        word_next.sat_rem = sat_num[2*CHANNEL_BITS-1:CHANNEL_BITS];
        word_next.sat_div = (vmax == '0) ? '1 : {1'b0, vmax};
        word_next.sat_low = sat_num[CHANNEL_BITS-1:0];
        word_next.sat_q   = '0;
        word_next.value   = vmax;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

FILE: hdl/rhsv_cell.sv
module rhsv_cell
    import rhsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hue_en,
    input  logic      sat_en,
    input  logic      up_valid,
    output logic      up_ready,
    input  div_word_t up_word,
    output logic      dn_valid,
    input  logic      dn_ready,
    output div_word_t dn_word
);

    logic [HDIV_BITS:0]    hue_try;
    logic                  hue_ge;
    logic [CHANNEL_BITS:0] sat_try;
    logic                  sat_ge;
    div_word_t             word_next;
    div_word_t             word_reg;
    logic                  valid_reg;

    // One restoring step for each divider
    assign hue_try = {up_word.hue_rem, 1'b0};
    assign hue_ge  = hue_try >= {1'b0, up_word.hue_div};
    assign sat_try = {up_word.sat_rem, up_word.sat_low[CHANNEL_BITS-1]};
    assign sat_ge  = sat_try >= up_word.sat_div;

    always_comb
    begin
        word_next = up_word;
        if (hue_en)
        begin
            word_next.hue_rem = hue_ge ? HDIV_BITS'(hue_try - {1'b0, up_word.hue_div})
                                       : hue_try[HDIV_BITS-1:0];
            word_next.hue_q   = {up_word.hue_q[HUE_BITS-2:0], hue_ge};
        end
        if (sat_en)
        begin
            word_next.sat_rem = sat_ge ? CHANNEL_BITS'(sat_try - up_word.sat_div)
                                       : sat_try[CHANNEL_BITS-1:0];
            word_next.sat_low = {up_word.sat_low[CHANNEL_BITS-2:0], 1'b0};
            word_next.sat_q   = {up_word.sat_q[CHANNEL_BITS-2:0], sat_ge};
        end
    end

    // Stage holds its word until the next cell takes it; bubbles collapse
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

FILE: hdl/rgb_to_hsv_pixel_unit.sv
// RGB to HSV converter. Takes one pixel per clock and returns one HSV word per
// pixel, in order, while the output is ready; throughput is then one word per
// cycle with no gaps. Pixels pass a max/min/chroma stage and then a chain of 16
// divider cells that each resolve one hue quotient bit and, in the first 8, one
// saturation quotient bit. Each pipeline stage only stalls when it holds a word
// the next stage cannot take, so empty slots fill even while the output waits.
// Hue is a fraction of a turn in units of 1/65536, saturation is
// floor(255*chroma/value), brightness is the largest channel; black gives
// saturation 0 and gray gives hue 0. Ties for the max go red, then green, then blue.
module rgb_to_hsv_pixel_unit
    import rhsv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // red, green, blue
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // hue, saturation, brightness
);

    div_word_t       word [STEPS+1];
    logic [STEPS:0]  valid;
    logic [STEPS:0]  ready;

    // Front stage: max, min, chroma and divider seeds
    rhsv_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_axis_tvalid),
        .up_ready (s_axis_tready),
        .up_data  (s_axis_tdata),
        .dn_valid (valid[0]),
        .dn_ready (ready[0]),
        .dn_word  (word[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        rhsv_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .hue_en   (1'(k < HUE_BITS)),
            .sat_en   (1'(k < CHANNEL_BITS)),
            .up_valid (valid[k]),
            .up_ready (ready[k]),
            .up_word  (word[k]),
            .dn_valid (valid[k+1]),
            .dn_ready (ready[k+1]),
            .dn_word  (word[k+1])
        );
    end

    // Last cell register is the output register
    assign ready[STEPS]  = m_axis_tready;
    assign m_axis_tvalid = valid[STEPS];
    assign m_axis_tdata  = OUT_TDATA_W'({word[STEPS].value, word[STEPS].sat_q,
                                         word[STEPS].hue_q});

endmodule

FILE: hdl/rhsv_checker.sv
module rhsv_checker
    import rhsv_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    hue_t  hue;
    chan_t sat;
    chan_t bright;

    assign hue    = m_axis_tdata[HUE_BITS-1:0];
    assign sat    = m_axis_tdata[HUE_BITS+CHANNEL_BITS-1:HUE_BITS];
    assign bright = m_axis_tdata[HUE_BITS+2*CHANNEL_BITS-1:HUE_BITS+CHANNEL_BITS];

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // Input is never blocked while the output side can move
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input blocked with output free");

    // Black pixel has no saturation
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (bright == '0) |-> (sat == '0))
        else $error("saturation nonzero for black pixel");

    // Zero saturation means zero chroma, hence zero hue
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (sat == '0) |-> (hue == '0))
        else $error("hue nonzero for gray pixel");

endmodule

bind rgb_to_hsv_pixel_unit rhsv_checker u_rhsv_checker (.*);
